[sv/point_in_triangle_test_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-triangle test
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent on the same edge
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_in_triangle_test: assertion failed");
// expression must never be true
`define PIT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("point_in_triangle_test: assertion failed");
`else
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[sv/pit_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-triangle test package
// Shared constants: default coordinate width, multiplier limb, pipeline depth.
// ----------------------------------------------------------------------------
package pit_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // limb width of the pipelined multipliers
    localparam int LIMB_BITS = 32;

    // start-to-strobe latency in cycles
    localparam int PIPE_LAT = 11;

endpackage

[sv/pit_cross.sv]
// ----------------------------------------------------------------------------
// Edge vectors and cross products
// Stage 1 forms u = B-A, v = C-A, w = P-A; stage 2 forms v x w, u x w, u x v.
// ----------------------------------------------------------------------------
module pit_cross #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic signed [COORD_BITS-1:0]  i_ax,
    input  logic signed [COORD_BITS-1:0]  i_ay,
    input  logic signed [COORD_BITS-1:0]  i_az,
    input  logic signed [COORD_BITS-1:0]  i_bx,
    input  logic signed [COORD_BITS-1:0]  i_by,
    input  logic signed [COORD_BITS-1:0]  i_bz,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    input  logic signed [COORD_BITS-1:0]  i_cz,
    input  logic signed [COORD_BITS-1:0]  i_px,
    input  logic signed [COORD_BITS-1:0]  i_py,
    input  logic signed [COORD_BITS-1:0]  i_pz,
    output logic signed [2*COORD_BITS+2:0] o_vw [3],
    output logic signed [2*COORD_BITS+2:0] o_uw [3],
    output logic signed [2*COORD_BITS+2:0] o_uv [3]
);

    localparam int DW = COORD_BITS + 1;       // difference width
    localparam int MW = 2 * COORD_BITS + 2;   // product width
    localparam int XW = 2 * COORD_BITS + 3;   // cross component width

    logic signed [DW-1:0] r_u [3];
    logic signed [DW-1:0] r_v [3];
    logic signed [DW-1:0] r_w [3];
    logic signed [XW-1:0] r_vw [3];
    logic signed [XW-1:0] r_uw [3];
    logic signed [XW-1:0] r_uv [3];

    // stage 1: edge vectors relative to A
    always_ff @(posedge i_clk) begin
        r_u[0] <= DW'(i_bx) - DW'(i_ax);
        r_u[1] <= DW'(i_by) - DW'(i_ay);
        r_u[2] <= DW'(i_bz) - DW'(i_az);
        r_v[0] <= DW'(i_cx) - DW'(i_ax);
        r_v[1] <= DW'(i_cy) - DW'(i_ay);
        r_v[2] <= DW'(i_cz) - DW'(i_az);
        r_w[0] <= DW'(i_px) - DW'(i_ax);
        r_w[1] <= DW'(i_py) - DW'(i_ay);
        r_w[2] <= DW'(i_pz) - DW'(i_az);
    end

    // cross product component: a[i]*b[j] - a[j]*b[i]
    function automatic logic signed [XW-1:0] xcomp(
        input logic signed [DW-1:0] a1, input logic signed [DW-1:0] b2,
        input logic signed [DW-1:0] a2, input logic signed [DW-1:0] b1
    );
        logic signed [MW-1:0] m1;
        logic signed [MW-1:0] m2;
        m1 = MW'(a1) * MW'(b2);
        m2 = MW'(a2) * MW'(b1);
        return XW'(m1) - XW'(m2);
    endfunction

    // stage 2: the three cross products
    always_ff @(posedge i_clk) begin
        r_vw[0] <= xcomp(r_v[1], r_w[2], r_v[2], r_w[1]);
        r_vw[1] <= xcomp(r_v[2], r_w[0], r_v[0], r_w[2]);
        r_vw[2] <= xcomp(r_v[0], r_w[1], r_v[1], r_w[0]);
        r_uw[0] <= xcomp(r_u[1], r_w[2], r_u[2], r_w[1]);
        r_uw[1] <= xcomp(r_u[2], r_w[0], r_u[0], r_w[2]);
        r_uw[2] <= xcomp(r_u[0], r_w[1], r_u[1], r_w[0]);
        r_uv[0] <= xcomp(r_u[1], r_v[2], r_u[2], r_v[1]);
        r_uv[1] <= xcomp(r_u[2], r_v[0], r_u[0], r_v[2]);
        r_uv[2] <= xcomp(r_u[0], r_v[1], r_u[1], r_v[0]);
    end

    assign o_vw = r_vw;
    assign o_uw = r_uw;
    assign o_uv = r_uv;

endmodule

[sv/pit_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Sign-magnitude, limb partial products (stage A), column sums (stage B), final sum and sign (stage C).
// ----------------------------------------------------------------------------
module pit_mul #(
    parameter int W = 2 * pit_pkg::COORD_BITS_DEF + 3
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    localparam int L  = pit_pkg::LIMB_BITS;
    localparam int K  = (W + L - 1) / L;
    localparam int CW = 2 * L + $clog2(K) + 1;
    localparam int SW = 2 * K * L;

    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [K*L-1:0] ea;
    logic [K*L-1:0] eb;
    logic [2*L-1:0] r_pp [K][K];
    logic           r_sgn1;
    logic [CW-1:0]  n_col [2*K-1];
    logic [CW-1:0]  r_col [2*K-1];
    logic           r_sgn2;
    logic [SW-1:0]  n_sum;
    logic [SW-1:0]  n_p;
    logic signed [2*W-1:0] r_p;

    // magnitudes, padded to whole limbs
    always_comb begin
        ma = i_a[W-1] ? W'(-i_a) : W'(i_a);
        mb = i_b[W-1] ? W'(-i_b) : W'(i_b);
        ea = (K*L)'(ma);
        eb = (K*L)'(mb);
    end

    // stage A: limb partial products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K; j++) begin
                r_pp[i][j] <= (2*L)'(ea[i*L +: L]) * (2*L)'(eb[j*L +: L]);
            end
        end
        r_sgn1 <= i_a[W-1] ^ i_b[W-1];
    end

    // column sums of equal weight
    always_comb begin
        for (int k = 0; k < 2*K-1; k++) begin
            n_col[k] = '0;
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K; j++) begin
                    if (i + j == k) begin
                        n_col[k] = n_col[k] + CW'(r_pp[i][j]);
                    end
                end
            end
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_sgn2 <= r_sgn1;
    end

    // final weighted sum and sign
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 2*K-1; k++) begin
            n_sum = n_sum + (SW'(r_col[k]) << (k*L));
        end
        n_p = r_sgn2 ? -n_sum : n_sum;
    end

    // stage C
    always_ff @(posedge i_clk) begin
        r_p <= signed'(n_p[2*W-1:0]);
    end

    assign o_p = r_p;

endmodule

[sv/point_in_triangle_test.sv]
// ----------------------------------------------------------------------------
// Point-in-triangle test, 3-D
// Exact barycentric inside test of P against triangle ABC, fully pipelined.
// ----------------------------------------------------------------------------
// One test enters per clock whenever start is high; busy is always low. Each
// result appears on o_inside_res with o_valid high for one cycle, in order,
// after passing through the edge vectors and cross products, the dot-product
// multipliers, the dot sums, the sign tests and c-a-b, the wide multipliers
// for a*b and d^2, and the final compare. The receiver cannot stall the
// pipeline. Edges count as inside; a degenerate triangle gives 0.
module point_in_triangle_test #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    output logic                         o_valid,
    output logic                         o_inside_res
);

`include "point_in_triangle_test_macros.svh"

    localparam int XW  = 2 * COORD_BITS + 3;  // cross component
    localparam int PW  = 2 * XW + 2;          // dot sums, squared lengths, d
    localparam int LAT = pit_pkg::PIPE_LAT;

    logic signed [XW-1:0]   vw [3];
    logic signed [XW-1:0]   uw [3];
    logic signed [XW-1:0]   uv [3];
    logic signed [2*XW-1:0] p_e1 [3];
    logic signed [2*XW-1:0] p_e2 [3];
    logic signed [2*XW-1:0] p_a [3];
    logic signed [2*XW-1:0] p_b [3];
    logic signed [2*XW-1:0] p_c [3];
    logic signed [PW-1:0]   r_e1, r_e2, r_a, r_b, r_c;
    logic signed [PW-1:0]   r_d;
    logic signed [PW-1:0]   r_a7, r_b7;
    logic                   r_ok7;
    logic [2:0]             r_ok_dly;
    logic signed [2*PW-1:0] p_ab, p_dd;
    logic [LAT-1:0]         r_vld;
    logic                   r_inside;
    logic                   accept;

    // never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // valid bits travel alongside the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // stages 1-2: edge vectors and cross products
    pit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .i_clk (i_clk),
        .i_ax (i_ax), .i_ay (i_ay), .i_az (i_az),
        .i_bx (i_bx), .i_by (i_by), .i_bz (i_bz),
        .i_cx (i_cx), .i_cy (i_cy), .i_cz (i_cz),
        .i_px (i_px), .i_py (i_py), .i_pz (i_pz),
        .o_vw (vw), .o_uw (uw), .o_uv (uv)
    );

    // stages 3-5: component products of the five dot products
    // v x u = -(u x v), so the first sign test uses vw . uv <= 0
    for (genvar k = 0; k < 3; k++) begin : g_dot
        pit_mul #(.W(XW)) u_e1 (.i_clk(i_clk), .i_a(vw[k]), .i_b(uv[k]), .o_p(p_e1[k]));
        pit_mul #(.W(XW)) u_e2 (.i_clk(i_clk), .i_a(uw[k]), .i_b(uv[k]), .o_p(p_e2[k]));
        pit_mul #(.W(XW)) u_a  (.i_clk(i_clk), .i_a(vw[k]), .i_b(vw[k]), .o_p(p_a[k]));
        pit_mul #(.W(XW)) u_b  (.i_clk(i_clk), .i_a(uw[k]), .i_b(uw[k]), .o_p(p_b[k]));
        pit_mul #(.W(XW)) u_c  (.i_clk(i_clk), .i_a(uv[k]), .i_b(uv[k]), .o_p(p_c[k]));
    end

    // stage 6: dot sums
    always_ff @(posedge i_clk) begin
        r_e1 <= PW'(p_e1[0]) + PW'(p_e1[1]) + PW'(p_e1[2]);
        r_e2 <= PW'(p_e2[0]) + PW'(p_e2[1]) + PW'(p_e2[2]);
        r_a  <= PW'(p_a[0]) + PW'(p_a[1]) + PW'(p_a[2]);
        r_b  <= PW'(p_b[0]) + PW'(p_b[1]) + PW'(p_b[2]);
        r_c  <= PW'(p_c[0]) + PW'(p_c[1]) + PW'(p_c[2]);
    end

    // stage 7: sign tests, degenerate check, d = c - a - b
    always_ff @(posedge i_clk) begin
        r_ok7 <= (r_e1[PW-1] || (r_e1 == '0)) && !r_e2[PW-1] && (r_c != '0);
        r_d   <= r_c - r_a - r_b;
        r_a7  <= r_a;
        r_b7  <= r_b;
    end

    // stages 8-10: a*b and d*d
    pit_mul #(.W(PW)) u_ab (.i_clk(i_clk), .i_a(r_a7), .i_b(r_b7), .o_p(p_ab));
    pit_mul #(.W(PW)) u_dd (.i_clk(i_clk), .i_a(r_d),  .i_b(r_d),  .o_p(p_dd));

    // flag delay alongside the wide multipliers; d must be non-negative
    always_ff @(posedge i_clk) begin
        r_ok_dly <= {r_ok_dly[1:0], r_ok7 & !r_d[PW-1]};
    end

    // stage 11: d^2 >= 4ab
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
        end else begin
            r_inside <= r_vld[LAT-2] && r_ok_dly[2] && (p_dd >= (p_ab <<< 2));
        end
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_inside_res = r_inside;

    // checks
    `PIT_ASSERT_IMPL(a_res_only_with_strobe, i_clk, i_rst_n, o_inside_res, o_valid)
    `PIT_ASSERT_IMPL(a_strobe_follows_start, i_clk, i_rst_n, o_valid, $past(accept, LAT))
    `PIT_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)

endmodule

[test/point_in_triangle_test_checker.sv]
// ----------------------------------------------------------------------------
// Point-in-triangle test checker
// Watches the command and result ports, predicts each answer exactly in wide
// integer arithmetic and compares results in order against the predictions.
// ----------------------------------------------------------------------------
module point_in_triangle_test_checker #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    input  logic                         o_valid,
    input  logic                         o_inside_res,
    output int                           o_fails,
    output int                           o_pending,
    output int                           o_words,
    output int                           o_insides
);

    typedef logic signed [255:0] wide_t;
    typedef longint vec3_t [3];

    bit verdicts_q[$];
    int mismatches = 0;
    int words_in = 0;
    int inside_cnt = 0;

    assign o_fails   = mismatches;
    assign o_pending = verdicts_q.size();
    assign o_words   = words_in;
    assign o_insides = inside_cnt;

    function automatic void cross3(input vec3_t p, input vec3_t q, output vec3_t r);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = p[2] * q[0] - p[0] * q[2];
        r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic wide_t dot3(input vec3_t p, input vec3_t q);
        return wide_t'(p[0]) * wide_t'(q[0]) + wide_t'(p[1]) * wide_t'(q[1])
             + wide_t'(p[2]) * wide_t'(q[2]);
    endfunction

    // exact inside verdict: sign tests, then squared-length comparison
    function automatic bit point_inside(input vec3_t pa, input vec3_t pb,
                                       input vec3_t pc, input vec3_t pp);
        vec3_t u, v, w, vw, vu, uw, uv;
        wide_t la, lb, lc, d;
        for (int i = 0; i < 3; i++) begin
            u[i] = pb[i] - pa[i];
            v[i] = pc[i] - pa[i];
            w[i] = pp[i] - pa[i];
        end
        cross3(v, w, vw);
        cross3(v, u, vu);
        cross3(u, w, uw);
        cross3(u, v, uv);
        if (dot3(vw, vu) < 0 || dot3(uw, uv) < 0) return 1'b0;
        la = dot3(vw, vw);
        lb = dot3(uw, uw);
        lc = dot3(uv, uv);
        // degenerate triangle
        if (lc == 0) return 1'b0;
        d = lc - la - lb;
        if (d < 0) return 1'b0;
        return (d * d - 4 * la * lb) >= 0;
    endfunction

    // sample accepted words and results on the same edge
    always @(posedge i_clk) begin
        vec3_t pa, pb, pc, pp;
        bit exp_bit;
        if (i_rst_n && start && !busy) begin
            pa = '{i_ax, i_ay, i_az};
            pb = '{i_bx, i_by, i_bz};
            pc = '{i_cx, i_cy, i_cz};
            pp = '{i_px, i_py, i_pz};
            exp_bit = point_inside(pa, pb, pc, pp);
            verdicts_q.push_back(exp_bit);
            words_in++;
            if (exp_bit) inside_cnt++;
        end
        if (i_rst_n && o_valid) begin
            if (verdicts_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0b with nothing expected", $time, o_inside_res);
            end else begin
                exp_bit = verdicts_q.pop_front();
                if (o_inside_res !== exp_bit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: inside_res expected %0b got %0b",
                                 $time, exp_bit, o_inside_res);
                end
            end
        end
    end

endmodule

[test/point_in_triangle_test_tb.sv]
// ----------------------------------------------------------------------------
// Point-in-triangle test bench
// Drives directed and random triangle queries with random gaps; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module point_in_triangle_test_tb;

    localparam int CB = pit_pkg::COORD_BITS_DEF;
    localparam int N_RANDOM = 800;

    typedef logic signed [CB-1:0] crd_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    crd_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
    crd_t cx = '0, cy = '0, cz = '0, px = '0, py = '0, pz = '0;
    logic o_valid, o_inside_res;
    int fails, pending, words, insides;

    always #5 i_clk = ~i_clk;

    point_in_triangle_test uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by(by), .i_bz(bz),
        .i_cx(cx), .i_cy(cy), .i_cz(cz), .i_px(px), .i_py(py), .i_pz(pz),
        .o_valid(o_valid), .o_inside_res(o_inside_res)
    );

    point_in_triangle_test_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by(by), .i_bz(bz),
        .i_cx(cx), .i_cy(cy), .i_cz(cz), .i_px(px), .i_py(py), .i_pz(pz),
        .o_valid(o_valid), .o_inside_res(o_inside_res),
        .o_fails(fails), .o_pending(pending), .o_words(words), .o_insides(insides)
    );

    // mostly no gap, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one word at the current edge and hold it until accepted
    task automatic send_word(input crd_t a[3], input crd_t b[3],
                             input crd_t c[3], input crd_t p[3]);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ax <= a[0]; ay <= a[1]; az <= a[2];
        bx <= b[0]; by <= b[1]; bz <= b[2];
        cx <= c[0]; cy <= c[1]; cz <= c[2];
        px <= p[0]; py <= p[1]; pz <= p[2];
        start <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    function automatic crd_t rnd_crd();
        return crd_t'($urandom());
    endfunction

    initial begin
        #20_000_000;
        $display("** point_in_triangle_test: FAILED **");
        $finish;
    end

    initial begin
        crd_t a[3], b[3], c[3], p[3];
        int s, t, uu[3], vv[3], base[3];
        crd_t mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, vertices, edge, centroid, outside, off-plane, extremes
        send_word('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        send_word('{0, 0, 0}, '{256, 0, 0}, '{512, 0, 0}, '{128, 0, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{0, 0, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{768, 0, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{384, 384, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{256, 256, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{385, 384, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{-1, 10, 0});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{100, 100, 500});
        send_word('{0, 0, 0}, '{768, 0, 0}, '{0, 768, 0}, '{800, 800, 0});
        send_word('{mn, mn, mn}, '{mx, mn, mn}, '{mn, mx, mn}, '{0, 0, mn});
        send_word('{mn, mn, mn}, '{mx, mn, mn}, '{mn, mx, mn}, '{mx, mx, mn});
        send_word('{mx, mx, mx}, '{mn, mx, mx}, '{mx, mn, mx}, '{mx, mx, mx});
        send_word('{mn, mn, mn}, '{mx, mx, mx}, '{mn, mx, mn}, '{mx, mn, mx});
        send_word('{mx, mn, mx}, '{mn, mx, mn}, '{mx, mx, mn}, '{-1, -1, -1});
        send_word('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1});

        // random: mostly points built from barycentric weights, the rest raw noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                foreach (a[i]) begin
                    a[i] = rnd_crd(); b[i] = rnd_crd(); c[i] = rnd_crd(); p[i] = rnd_crd();
                end
            end else begin
                s = $urandom_range(0, 8);
                t = $urandom_range(0, 8 - s);
                if ($urandom_range(0, 4) == 0) s = s + 1;
                for (int i = 0; i < 3; i++) begin
                    base[i] = $signed($urandom_range(0, 4000)) - 2000;
                    uu[i] = $signed($urandom_range(0, 200)) - 100;
                    vv[i] = $signed($urandom_range(0, 200)) - 100;
                    a[i] = crd_t'(base[i]);
                    b[i] = crd_t'(base[i] + 8 * uu[i]);
                    c[i] = crd_t'(base[i] + 8 * vv[i]);
                    p[i] = crd_t'(base[i] + s * uu[i] + t * vv[i]
                                  + (($urandom_range(0, 3) == 0) ?
                                     $signed($urandom_range(0, 2)) - 1 : 0));
                end
            end
            send_word(a, b, c, p);
        end
        start <= 1'b0;

        // drain the pipeline
        while (pending != 0) @(posedge i_clk);
        repeat (pit_pkg::PIPE_LAT + 5) @(posedge i_clk);

        $display("Ran %0d triangle queries, %0d predicted inside, %0d outside.",
                 words, insides, words - insides);
        if (fails == 0 && pending == 0)
            $display("** point_in_triangle_test: PASSED **");
        else
            $display("** point_in_triangle_test: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/pit_pkg.sv
sv/pit_cross.sv
sv/pit_mul.sv
sv/point_in_triangle_test.sv
test/point_in_triangle_test_checker.sv
test/point_in_triangle_test_tb.sv
